FILE: rtl/ftla_pkg.sv
// Shared types and codes for the exact-match flow table.
package ftla_pkg;

	// Default geometry
	localparam int TABLE_DEPTH_DEF   = 256;
	localparam int KEY_HIGH_BITS_DEF = 40;
	localparam int KEY_LOW_BITS      = 64;
	localparam int CFG_W             = 9;
	localparam logic [CFG_W-1:0] TABLE_LIMIT_RST = 9'd256;

	// Request modes
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_ALLOC  = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_MISS     = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_DELETED  = 3'd4;
	localparam logic [2:0] ST_DEL_MISS = 3'd5;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic cmp;   // capture compare result
		logic wr;    // store the presented key and mark valid
		logic del;   // clear valid where the last compare hit
	} ftla_cell_ctrl_t;

endpackage

FILE: rtl/ftla_cell.sv
// One slot of the flow table: stored key, valid bit and compare.
module ftla_cell #(
	parameter int KEY_HIGH_BITS = ftla_pkg::KEY_HIGH_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ftla_pkg::ftla_cell_ctrl_t             ctrl,
	input  logic [ftla_pkg::KEY_LOW_BITS-1:0]     key_low,
	input  logic [KEY_HIGH_BITS-1:0]              key_high,
	output logic                                  hit
);
	import ftla_pkg::*;

	logic [KEY_LOW_BITS-1:0]  key_low_q;
	logic [KEY_HIGH_BITS-1:0] key_high_q;
	logic                     valid_q;
	logic                     hit_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			key_low_q  <= key_low;
			key_high_q <= key_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctrl.wr) begin
				valid_q <= 1'b1;
			end else if (ctrl.del && hit_q) begin
				valid_q <= 1'b0;
			end
			if (ctrl.cmp) begin
				hit_q <= valid_q && (key_low_q == key_low) && (key_high_q == key_high);
			end
		end
	end

	assign hit = hit_q;

endmodule

FILE: rtl/ftla_match_tree.sv
// Registered binary tree that turns the row of hit flags into a match index.
module ftla_match_tree #(
	parameter int TABLE_DEPTH = ftla_pkg::TABLE_DEPTH_DEF,
	localparam int LVL        = $clog2(TABLE_DEPTH),
	localparam int IDX_W      = LVL
) (
	input  logic                   clk,
	input  logic [TABLE_DEPTH-1:0] hit,
	output logic                   found,
	output logic [IDX_W-1:0]       idx
);
	import ftla_pkg::*;

	localparam int P = 1 << LVL;

	logic             leaf_any [P];
	logic [IDX_W-1:0] leaf_idx [P];
	logic             any_q [1:LVL][P];
	logic [IDX_W-1:0] idx_q [1:LVL][P];

	// Leaf level: one node per slot, padded to a power of two
	always_comb begin
		for (int n = 0; n < P; n++) begin
			leaf_any[n] = (n < TABLE_DEPTH) ? hit[n] : 1'b0;
			leaf_idx[n] = IDX_W'(n);
		end
	end

	// Keys are unique, so at most one leaf is set; the lower child wins anyway
	for (genvar l = 1; l <= LVL; l++) begin : g_lvl
		if (l == 1) begin : g_first
			always_ff @(posedge clk) begin
				for (int n = 0; n < P; n++) begin
					if (2 * n + 1 < P) begin
						any_q[l][n] <= leaf_any[2*n] || leaf_any[2*n+1];
						idx_q[l][n] <= leaf_any[2*n] ? leaf_idx[2*n] : leaf_idx[2*n+1];
					end else begin
						any_q[l][n] <= 1'b0;
						idx_q[l][n] <= '0;
					end
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				for (int n = 0; n < P; n++) begin
					if (2 * n + 1 < P) begin
						any_q[l][n] <= any_q[l-1][2*n] || any_q[l-1][2*n+1];
						idx_q[l][n] <= any_q[l-1][2*n] ? idx_q[l-1][2*n]
						                               : idx_q[l-1][2*n+1];
					end else begin
						any_q[l][n] <= 1'b0;
						idx_q[l][n] <= '0;
					end
				end
			end
		end
	end

	assign found = any_q[LVL][0];
	assign idx   = idx_q[LVL][0];

endmodule

FILE: rtl/flow_table_lookup_alloc.sv
// Top level of the exact-match flow table with bump allocation.
//
// Exact-match flow table. Each request transaction carries a flow key
// (key_low, key_high) and a mode: lookup, lookup-or-allocate, or delete. The
// key is held in a row of TABLE_DEPTH identical cells, each storing one slot
// and comparing its key against the presented one in the same cycle. The
// per-cell hit flags drain through a registered binary tree of
// $clog2(TABLE_DEPTH) levels that yields the matching slot. A new key is
// stored at the slot named by a bump counter that only grows, so a slot freed
// by a delete is never handed out again; allocation reports full once the
// counter reaches min(table_limit, TABLE_DEPTH). Each request gives exactly
// one result transaction with status, index, new-entry flag and live count.
// A request is taken only in S_IDLE, compared in S_CMP, passed through the
// tree levels in S_TREE (the tree depth sets its length) and applied in
// S_DONE. The result sits in an output register, so the next request is
// taken while an earlier result still waits; S_DONE holds only if that
// register is still occupied. The user must write table_limit through
// cfg_we / cfg_wdata only while the block is idle; the block itself does
// not enforce this. Stored keys need no reset; only the valid bits clear.
module flow_table_lookup_alloc #(
	parameter int TABLE_DEPTH   = ftla_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_HIGH_BITS = ftla_pkg::KEY_HIGH_BITS_DEF,
	localparam int IDX_W        = $clog2(TABLE_DEPTH),
	localparam int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [ftla_pkg::CFG_W-1:0]         cfg_wdata,
	// request channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         mode,
	input  logic [ftla_pkg::KEY_LOW_BITS-1:0]  key_low,
	input  logic [KEY_HIGH_BITS-1:0]           key_high,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         status,
	output logic [IDX_W-1:0]                   entry_index,
	output logic                               is_new,
	output logic [CNT_W-1:0]                   live_count
);
	import ftla_pkg::*;

	localparam int LVL     = IDX_W;
	localparam int TREE_CW = (LVL > 1) ? $clog2(LVL) : 1;
	localparam int CMP_W   = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_TREE = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [TREE_CW-1:0]       tree_cnt_q;
	logic [CFG_W-1:0]         limit_q;
	logic [CNT_W-1:0]         next_q;
	logic [CNT_W-1:0]         held_q;

	// Request held for the life of the transaction
	logic [1:0]               mode_q;
	logic [KEY_LOW_BITS-1:0]  key_low_q;
	logic [KEY_HIGH_BITS-1:0] key_high_q;

	// Result register
	logic                     out_valid_q;
	logic [2:0]               status_q;
	logic [IDX_W-1:0]         index_q;
	logic                     new_q;
	logic [CNT_W-1:0]         live_q;

	ftla_cell_ctrl_t          cell_ctrl [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]   hit_vec;
	logic                     found;
	logic [IDX_W-1:0]         found_idx;

	logic                     in_acc;
	logic                     out_free;
	logic                     finish;
	logic                     do_wr;
	logic                     do_del;
	logic                     full;
	logic [CMP_W-1:0]         eff_limit;
	logic [2:0]               status_d;
	logic [IDX_W-1:0]         index_d;
	logic [CNT_W-1:0]         held_d;
	logic [CNT_W-1:0]         next_d;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == S_DONE) && out_free;

	// Clamp the limit to the depth, then test the bump counter against it
	always_comb begin
		eff_limit = (CMP_W'(limit_q) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH)
		                                                    : CMP_W'(limit_q);
		full      = CMP_W'(next_q) >= eff_limit;
	end

	// Decide the outcome once the tree has settled
	always_comb begin
		status_d = ST_MISS;
		index_d  = '0;
		do_wr    = 1'b0;
		do_del   = 1'b0;
		held_d   = held_q;
		next_d   = next_q;
		case (mode_q)
			MODE_DELETE: begin
				if (found) begin
					status_d = ST_DELETED;
					do_del   = 1'b1;
					if (held_q != '0) begin
						held_d = held_q - CNT_W'(1);
					end
				end else begin
					status_d = ST_DEL_MISS;
				end
			end
			MODE_ALLOC: begin
				if (found) begin
					status_d = ST_HIT;
					index_d  = found_idx;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_NEW;
					index_d  = next_q[IDX_W-1:0];
					do_wr    = 1'b1;
					held_d   = held_q + CNT_W'(1);
					next_d   = next_q + CNT_W'(1);
				end
			end
			default: begin
				// plain lookup; the unused mode code behaves the same
				if (found) begin
					status_d = ST_HIT;
					index_d  = found_idx;
				end
			end
		endcase
	end

	// Row of cells: compare broadcast, write steered by the bump index
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		always_comb begin
			cell_ctrl[i].cmp = (state_q == S_CMP);
			cell_ctrl[i].wr  = finish && do_wr && (next_q[IDX_W-1:0] == IDX_W'(i));
			cell_ctrl[i].del = finish && do_del;
		end

		ftla_cell #(
			.KEY_HIGH_BITS(KEY_HIGH_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl[i]),
			.key_low  (key_low_q),
			.key_high (key_high_q),
			.hit      (hit_vec[i])
		);
	end

	ftla_match_tree #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_tree (
		.clk   (clk),
		.hit   (hit_vec),
		.found (found),
		.idx   (found_idx)
	);

	// Capture the request on acceptance and the result on finish
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q     <= mode;
			key_low_q  <= key_low;
			key_high_q <= key_high;
		end
		if (finish) begin
			status_q <= status_d;
			index_q  <= index_d;
			new_q    <= do_wr;
			live_q   <= held_d;
		end
	end

	// Sequencer, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tree_cnt_q  <= '0;
			limit_q     <= TABLE_LIMIT_RST;
			next_q      <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					tree_cnt_q <= '0;
					state_q    <= S_TREE;
				end
				S_TREE: begin
					// advance one tree level a cycle
					if (tree_cnt_q == TREE_CW'(LVL - 1)) begin
						state_q <= S_DONE;
					end else begin
						tree_cnt_q <= tree_cnt_q + TREE_CW'(1);
					end
				end
				S_DONE: begin
					// hold until the result register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (finish) begin
				next_q      <= next_d;
				held_q      <= held_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;
	assign is_new      = new_q;
	assign live_count  = live_q;

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_held_le_next: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= next_q)
		else $error("live count exceeds handed-out indices");

	a_next_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(next_q) <= CMP_W'(TABLE_DEPTH))
		else $error("bump counter beyond table depth");

	a_new_bumps: assert property (@(posedge clk) disable iff (!arst_n)
		finish && do_wr |=> next_q == $past(next_q) + CNT_W'(1))
		else $error("allocation did not advance the bump counter");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && !out_free |=> out_valid_q && $stable(status_q))
		else $error("pending result overwritten");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the exact-match flow table with bump allocation.
module tb;
	import ftla_pkg::*;

	localparam int DEPTH          = TABLE_DEPTH_DEF;
	localparam int HB             = KEY_HIGH_BITS_DEF;
	localparam int POOL_SIZE      = 64;
	localparam int PHASE_ITEMS    = 250;
	localparam int HOLD_AT        = 400;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 30;

	typedef struct packed {
		logic [1:0]              mode;
		logic [KEY_LOW_BITS-1:0] key_low;
		logic [HB-1:0]           key_high;
	} flow_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] entry_index;
		logic       is_new;
		logic [8:0] live_count;
	} flow_res_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_W-1:0]        cfg_wdata = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [1:0]              mode      = MODE_LOOKUP;
	logic [KEY_LOW_BITS-1:0] key_low   = '0;
	logic [HB-1:0]           key_high  = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [2:0]              status;
	logic [7:0]              entry_index;
	logic                    is_new;
	logic [8:0]              live_count;

	// Requests waiting to be offered, and results predicted but not yet seen
	flow_req_t pending_reqs[$];
	flow_res_t awaited_results[$];

	// Shadow copy of the flow table
	logic [KEY_LOW_BITS-1:0] shadow_lo [DEPTH];
	logic [HB-1:0]           shadow_hi [DEPTH];
	bit                      shadow_valid [DEPTH];
	int unsigned             shadow_next;
	int unsigned             shadow_held;
	int unsigned             shadow_limit;

	flow_req_t key_pool [POOL_SIZE];
	flow_req_t drive_req;
	flow_res_t seen_res;
	flow_res_t want_res;
	bit        steady      = 1'b0;
	int        fail_count  = 0;
	int        results_seen;
	int        hold_left;
	int        quiet_cycles;

	flow_table_lookup_alloc DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.key_low     (key_low),
		.key_high    (key_high),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_index (entry_index),
		.is_new      (is_new),
		.live_count  (live_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow table and return the result it should give.
	// Search every valid slot, then delete, hit, allocate or miss as the mode asks.
	function automatic flow_res_t table_update(flow_req_t req);
		flow_res_t   res;
		int unsigned cap;
		int unsigned slot;
		bit          found;
		res   = '0;
		found = 1'b0;
		slot  = 0;
		// a limit beyond the table depth is clamped to the depth
		cap = (shadow_limit > DEPTH) ? DEPTH : shadow_limit;
		for (int i = 0; i < DEPTH; i++) begin
			if (!found && shadow_valid[i] && shadow_lo[i] == req.key_low &&
					shadow_hi[i] == req.key_high) begin
				found = 1'b1;
				slot  = i;
			end
		end
		if (req.mode == MODE_DELETE) begin
			if (found) begin
				// free the slot but never hand the index out again
				shadow_valid[slot] = 1'b0;
				if (shadow_held > 0)
					shadow_held--;
				res.status = ST_DELETED;
			end else begin
				res.status = ST_DEL_MISS;
			end
		end else if (found) begin
			res.status      = ST_HIT;
			res.entry_index = 8'(slot);
		end else if (req.mode == MODE_ALLOC) begin
			if (shadow_next >= cap) begin
				res.status = ST_FULL;
			end else begin
				shadow_lo[shadow_next]    = req.key_low;
				shadow_hi[shadow_next]    = req.key_high;
				shadow_valid[shadow_next] = 1'b1;
				res.status      = ST_NEW;
				res.entry_index = 8'(shadow_next);
				res.is_new      = 1'b1;
				shadow_next++;
				shadow_held++;
			end
		end else begin
			// plain lookup, and the unused mode behaves the same way
			res.status = ST_MISS;
		end
		res.live_count = 9'(shadow_held);
		return res;
	endfunction

	function automatic flow_req_t make_req(logic [1:0] m, logic [KEY_LOW_BITS-1:0] lo,
			logic [HB-1:0] hi);
		flow_req_t req;
		req.mode     = m;
		req.key_low  = lo;
		req.key_high = hi;
		return req;
	endfunction

	function automatic flow_req_t fresh_key();
		return make_req(2'($urandom), {$urandom(), $urandom()}, HB'({$urandom(), $urandom()}));
	endfunction

	// Draw a random request: mostly keys from a small pool so that hits, deletes and
	// re-allocations happen often, some near misses one bit away, and some fresh keys.
	function automatic flow_req_t random_req();
		flow_req_t   req;
		int unsigned pick;
		int unsigned bit_pos;
		pick = $urandom_range(99);
		if (pick < 65) begin
			req = key_pool[$urandom_range(POOL_SIZE - 1)];
		end else if (pick < 78) begin
			req = key_pool[$urandom_range(POOL_SIZE - 1)];
			bit_pos = $urandom_range(KEY_LOW_BITS + HB - 1);
			if (bit_pos < KEY_LOW_BITS)
				req.key_low[bit_pos] = ~req.key_low[bit_pos];
			else
				req.key_high[bit_pos - KEY_LOW_BITS] = ~req.key_high[bit_pos - KEY_LOW_BITS];
		end else begin
			req = fresh_key();
		end
		pick = $urandom_range(99);
		if (pick < 45)
			req.mode = MODE_ALLOC;
		else if (pick < 70)
			req.mode = MODE_LOOKUP;
		else if (pick < 90)
			req.mode = MODE_DELETE;
		else
			req.mode = 2'b11;
		return req;
	endfunction

	// Driver: predict each accepted transaction, then offer the next pending request.
	// Hold valid and payload steady until the block takes them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(table_update(make_req(mode, key_low, key_high)));
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
					drive_req = pending_reqs.pop_front();
					in_valid  <= 1'b1;
					mode      <= drive_req.mode;
					key_low   <= drive_req.key_low;
					key_high  <= drive_req.key_high;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction against the oldest prediction.
	// After a set number of results, drop ready for a long stretch so the block
	// fills up and stalls its request side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready    <= 1'b0;
			results_seen = 0;
			hold_left    = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen_res = '{status, entry_index, is_new, live_count};
				if (awaited_results.size() == 0) begin
					$error("result with none expected: status %0d index %0d",
						seen_res.status, seen_res.entry_index);
					fail_count++;
				end else begin
					want_res = awaited_results.pop_front();
					if (seen_res.status !== want_res.status) begin
						$error("status: expected %0d, got %0d", want_res.status, seen_res.status);
						fail_count++;
					end
					if (seen_res.entry_index !== want_res.entry_index) begin
						$error("entry_index: expected %0d, got %0d",
							want_res.entry_index, seen_res.entry_index);
						fail_count++;
					end
					if (seen_res.is_new !== want_res.is_new) begin
						$error("is_new: expected %0d, got %0d", want_res.is_new, seen_res.is_new);
						fail_count++;
					end
					if (seen_res.live_count !== want_res.live_count) begin
						$error("live_count: expected %0d, got %0d",
							want_res.live_count, seen_res.live_count);
						fail_count++;
					end
				end
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 31);
			end
		end
	end

	// Watchdog: end the run if no transaction moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Wait until every request has been taken and every result has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	// Write table_limit while the block is idle and mirror it in the shadow copy
	task automatic write_limit(logic [CFG_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= value;
		shadow_limit = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [KEY_LOW_BITS-1:0] lo_ones;
		logic [HB-1:0]           hi_ones;
		flow_req_t               key_a;
		flow_req_t               key_b;
		flow_req_t               key_c;
		int unsigned             phase_limits [6];

		lo_ones = '1;
		hi_ones = '1;
		for (int i = 0; i < DEPTH; i++) begin
			shadow_lo[i]    = '0;
			shadow_hi[i]    = '0;
			shadow_valid[i] = 1'b0;
		end
		shadow_next  = 0;
		shadow_held  = 0;
		shadow_limit = TABLE_LIMIT_RST;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = fresh_key();

		// hold reset, then release it on a clock edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset limit: key extremes, every mode, no reuse of a
		// deleted index, and keys that differ only in the high or low part.
		pending_reqs.push_back(make_req(MODE_ALLOC,  '0, '0));
		pending_reqs.push_back(make_req(MODE_ALLOC,  lo_ones, hi_ones));
		pending_reqs.push_back(make_req(MODE_LOOKUP, '0, '0));
		pending_reqs.push_back(make_req(MODE_LOOKUP, lo_ones, hi_ones));
		pending_reqs.push_back(make_req(2'b11,       lo_ones, hi_ones));
		pending_reqs.push_back(make_req(2'b11,       lo_ones, '0));
		pending_reqs.push_back(make_req(MODE_LOOKUP, '0, hi_ones));
		pending_reqs.push_back(make_req(MODE_ALLOC,  lo_ones, hi_ones));
		pending_reqs.push_back(make_req(MODE_DELETE, lo_ones, hi_ones));
		pending_reqs.push_back(make_req(MODE_DELETE, lo_ones, hi_ones));
		pending_reqs.push_back(make_req(MODE_LOOKUP, lo_ones, hi_ones));
		pending_reqs.push_back(make_req(MODE_ALLOC,  lo_ones, hi_ones));
		pending_reqs.push_back(make_req(MODE_DELETE, lo_ones, '0));

		// Limit of zero: every allocation of a new key is full, lookups still hit
		write_limit('0);
		pending_reqs.push_back(make_req(MODE_ALLOC,  lo_ones, '0));
		pending_reqs.push_back(make_req(MODE_LOOKUP, '0, '0));

		// Limit below the counter: allocation stays full
		write_limit(9'd1);
		pending_reqs.push_back(make_req(MODE_ALLOC, '0, hi_ones));

		// Small limit: fill to it, then check a freed index does not open room
		write_limit(9'd5);
		key_a = fresh_key();
		key_b = fresh_key();
		key_c = fresh_key();
		pending_reqs.push_back(make_req(MODE_ALLOC,  key_a.key_low, key_a.key_high));
		pending_reqs.push_back(make_req(MODE_ALLOC,  key_b.key_low, key_b.key_high));
		pending_reqs.push_back(make_req(MODE_ALLOC,  key_c.key_low, key_c.key_high));
		pending_reqs.push_back(make_req(MODE_DELETE, key_a.key_low, key_a.key_high));
		pending_reqs.push_back(make_req(MODE_ALLOC,  key_a.key_low, key_a.key_high));

		// Random phases, each under its own limit; the largest values go past the depth
		phase_limits[0] = 40;
		phase_limits[1] = 120;
		phase_limits[2] = $urandom_range(DEPTH, 1);
		phase_limits[3] = 300;
		phase_limits[4] = 511;
		phase_limits[5] = DEPTH;
		foreach (phase_limits[p]) begin
			write_limit(CFG_W'(phase_limits[p]));
			// one phase runs with no idling on either side
			steady = (p == 2);
			// refresh part of the pool so new keys keep arriving
			for (int i = 0; i < POOL_SIZE / 4; i++)
				key_pool[$urandom_range(POOL_SIZE - 1)] = fresh_key();
			for (int n = 0; n < PHASE_ITEMS; n++)
				pending_reqs.push_back(random_req());
		end

		wait_drained();
		steady = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
